// ===== src/jssd_pkg.sv =====
// ----------------------------------------------------------------------------
// jssd_pkg
// Shared types, reset values and the half-step coil table for the
// joystick stepper half-step drive.
// ----------------------------------------------------------------------------
package jssd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 10;  // converter resolution
  localparam int unsigned REG_BITS        = 10;  // threshold register width
  localparam int unsigned IVL_BITS        = 5;   // step interval width
  localparam int unsigned COIL_BITS       = 4;
  localparam int unsigned PHASE_BITS      = 3;
  localparam int unsigned MODE_BITS       = 2;
  localparam int unsigned CFG_IDX_BITS    = 2;

  localparam int unsigned DIGIT_CNT_BITS  = $clog2(IVL_BITS);
  localparam logic [DIGIT_CNT_BITS-1:0] LAST_DIGIT = DIGIT_CNT_BITS'(IVL_BITS - 1);

  localparam logic [REG_BITS-1:0] FWD_THR_RST = REG_BITS'(600);
  localparam logic [REG_BITS-1:0] REV_THR_RST = REG_BITS'(400);
  localparam logic [IVL_BITS-1:0] FAST_RST    = IVL_BITS'(2);
  localparam logic [IVL_BITS-1:0] SLOW_RST    = IVL_BITS'(30);
  localparam logic [IVL_BITS-1:0] TICK_MAX    = IVL_BITS'(31);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_IDLE = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_REV  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FWD_THR = 2'd0,
    REG_REV_THR = 2'd1,
    REG_FAST    = 2'd2,
    REG_SLOW    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  // Half-step coil sequence
  function automatic logic [COIL_BITS-1:0] half_step(input logic [PHASE_BITS-1:0] ph);
    logic [COIL_BITS-1:0] pat;
    begin
      unique case (ph)
        3'd0:    pat = 4'b0001;
        3'd1:    pat = 4'b0011;
        3'd2:    pat = 4'b0010;
        3'd3:    pat = 4'b0110;
        3'd4:    pat = 4'b0100;
        3'd5:    pat = 4'b1100;
        3'd6:    pat = 4'b1000;
        default: pat = 4'b1001;
      endcase
      return pat;
    end
  endfunction

endpackage

// ===== src/jssd_mul.sv =====
// ----------------------------------------------------------------------------
// jssd_mul
// Bit-serial shift-and-add multiplier: operand by a 5-bit magnitude,
// one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module jssd_mul #(
  parameter int unsigned OPW = jssd_pkg::REG_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [OPW-1:0]                        op_a,
  input  logic [jssd_pkg::IVL_BITS-1:0]         op_b,
  output logic                                  done,
  output logic [OPW+jssd_pkg::IVL_BITS-1:0]     prod
);

  localparam int unsigned PW = OPW + jssd_pkg::IVL_BITS;

  logic [PW-1:0]                          acc_r;
  logic [PW-1:0]                          a_r;
  logic [jssd_pkg::IVL_BITS-1:0]          b_r;
  logic [jssd_pkg::DIGIT_CNT_BITS-1:0]    cnt_r;
  logic                                   run_r;
  logic                                   done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == jssd_pkg::LAST_DIGIT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= PW'(op_a);
      b_r   <= op_b;
    end else if (run_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== src/jssd_div.sv =====
// ----------------------------------------------------------------------------
// jssd_div
// Restoring divider producing a 5-bit quotient, one bit per cycle.
// Caller guarantees the quotient fits; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module jssd_div #(
  parameter int unsigned OPW = jssd_pkg::REG_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [OPW+jssd_pkg::IVL_BITS-1:0]     num,
  input  logic [OPW-1:0]                        den,
  output logic                                  done,
  output logic [jssd_pkg::IVL_BITS-1:0]         quo
);

  localparam int unsigned PW = OPW + jssd_pkg::IVL_BITS;

  logic [PW-1:0]                          rem_r;
  logic [PW-1:0]                          den_r;
  logic [jssd_pkg::IVL_BITS-1:0]          quo_r;
  logic                                   zero_r;
  logic [jssd_pkg::DIGIT_CNT_BITS-1:0]    cnt_r;
  logic                                   run_r;
  logic                                   done_r;
  logic                                   ge;

  assign ge = (rem_r >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == jssd_pkg::LAST_DIGIT) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= PW'(den) << (jssd_pkg::IVL_BITS - 1);
      quo_r  <= '0;
      zero_r <= (den == '0);
    end else if (run_r) begin
      if (ge) begin
        rem_r <= rem_r - den_r;
      end
      quo_r <= {quo_r[jssd_pkg::IVL_BITS-2:0], ge};
      den_r <= den_r >> 1;
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : quo_r;

endmodule

// ===== src/joystick_stepper_half_step_drive.sv =====
// ----------------------------------------------------------------------------
// joystick_stepper_half_step_drive
// Half-step stepper sequencer steered by a joystick sample per tick.
//
// Use: each in_ item is one tick carrying a joystick sample. Every item gives
// exactly one out_ item: coil pattern, step flag, run mode and the step
// interval worked out for that tick. Thresholds and intervals are written on
// the cfg_ channel (always ready); the user must write them only while the
// block is idle, as the block itself does not enforce it.
// Mapping: a forward or reverse item runs the interval mapping, a bit-serial
// multiplier and then a restoring divider; an idle-mode item skips both.
// Flow: one item in flight at a time; in_tready is high only in the idle
// state, so a new item is taken only once the last has left the done state.
// Stall: the result sits in an output register; a new item is accepted while
// it waits, and a finished item waits in the done state until the register
// frees, so nothing is dropped. Mode, and the clearing of tick and phase on a
// mode change, take effect at accept; stepping happens when the result loads.
// Reset: synchronous, active low. Registers return to 600/400/2/30, mode
// idle, phase, tick count and coils to zero.
// ----------------------------------------------------------------------------
module joystick_stepper_half_step_drive #(
  parameter int unsigned SAMPLE_BITS = jssd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // [SAMPLE_BITS-1:0] joystick_sample
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [15:0]                           out_tdata,  // [3:0] coil_pattern, [4] stepped,
                                                            // [6:5] run_mode, [11:7] step_interval
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [jssd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [jssd_pkg::REG_BITS-1:0]         cfg_data
);

  // Compare width covers both the sample and the 10-bit thresholds
  localparam int unsigned W  = (SAMPLE_BITS > jssd_pkg::REG_BITS) ? SAMPLE_BITS
                                                                  : jssd_pkg::REG_BITS;
  localparam int unsigned IB = jssd_pkg::IVL_BITS;
  localparam logic [W-1:0] MAXV = W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // config registers
  logic [jssd_pkg::REG_BITS-1:0] fwd_thr_r, rev_thr_r;
  logic [IB-1:0]                 fast_r, slow_r;

  // sequencer state
  jssd_pkg::state_t state_r, state_nxt;
  jssd_pkg::mode_t  mode_r, mode_in;
  logic [jssd_pkg::PHASE_BITS-1:0] phase_r;
  logic [IB-1:0]                   tick_r;
  logic [jssd_pkg::COIL_BITS-1:0]  coil_r;
  logic [IB-1:0]                   base_r;
  logic                            sub_r;
  logic [W-1:0]                    den_r;
  logic [IB-1:0]                   ivl_r;

  // output register
  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;

  // datapath
  logic [W-1:0]        s_w, ft_w, rt_w, mul_a;
  logic [IB:0]         diff;
  logic [IB-1:0]       mag;
  logic                accept, out_free, load;
  logic                mul_done, div_done;
  logic [W+IB-1:0]     prod;
  logic [IB-1:0]       quo;
  logic [IB+1:0]       ivl_sum;
  logic [IB-1:0]       tick_inc;
  logic                active, fire;

  assign s_w  = W'(in_tdata[SAMPLE_BITS-1:0]);
  assign ft_w = W'(fwd_thr_r);
  assign rt_w = W'(rev_thr_r);

  always_comb begin
    if (s_w >= ft_w) begin
      mode_in = jssd_pkg::MODE_FWD;
    end else if (s_w <= rt_w) begin
      mode_in = jssd_pkg::MODE_REV;
    end else begin
      mode_in = jssd_pkg::MODE_IDLE;
    end
  end

  // signed span of the interval range; work on its magnitude
  assign diff  = {1'b0, slow_r} - {1'b0, fast_r};
  assign mag   = diff[IB] ? IB'(-diff) : diff[IB-1:0];
  assign mul_a = (mode_in == jssd_pkg::MODE_FWD) ? (s_w - ft_w) : s_w;

  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign load      = (state_r == jssd_pkg::ST_DONE) && out_free;

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jssd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      jssd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = (mode_in == jssd_pkg::MODE_IDLE) ? jssd_pkg::ST_DONE
                                                       : jssd_pkg::ST_MUL;
        end
      end
      jssd_pkg::ST_MUL: begin
        if (mul_done) state_nxt = jssd_pkg::ST_DIV;
      end
      jssd_pkg::ST_DIV: begin
        if (div_done) state_nxt = jssd_pkg::ST_DONE;
      end
      jssd_pkg::ST_DONE: begin
        if (out_free) state_nxt = jssd_pkg::ST_IDLE;
      end
      default: state_nxt = jssd_pkg::ST_IDLE;
    endcase
  end

  // ---- serial arithmetic ----
  jssd_mul #(.OPW(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && (mode_in != jssd_pkg::MODE_IDLE)),
    .op_a  (mul_a),
    .op_b  (mag),
    .done  (mul_done),
    .prod  (prod)
  );

  jssd_div #(.OPW(W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_done),
    .num   (prod),
    .den   (den_r),
    .done  (div_done),
    .quo   (quo)
  );

  // forward: slow - q*sign, reverse: fast + q*sign; result stays between them
  assign ivl_sum = sub_r ? ({2'b00, base_r} - {2'b00, quo})
                         : ({2'b00, base_r} + {2'b00, quo});

  // ---- config writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_thr_r <= jssd_pkg::FWD_THR_RST;
      rev_thr_r <= jssd_pkg::REV_THR_RST;
      fast_r    <= jssd_pkg::FAST_RST;
      slow_r    <= jssd_pkg::SLOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jssd_pkg::REG_FWD_THR: fwd_thr_r <= cfg_data;
        jssd_pkg::REG_REV_THR: rev_thr_r <= cfg_data;
        jssd_pkg::REG_FAST:    fast_r    <= cfg_data[IB-1:0];
        jssd_pkg::REG_SLOW:    slow_r    <= cfg_data[IB-1:0];
        default: ;
      endcase
    end
  end

  // operands held for the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      den_r  <= (mode_in == jssd_pkg::MODE_FWD) ? (MAXV - ft_w) : rt_w;
      base_r <= (mode_in == jssd_pkg::MODE_FWD) ? slow_r : fast_r;
      sub_r  <= (mode_in == jssd_pkg::MODE_FWD) ^ diff[IB];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ivl_r <= '0;
    end else if (div_done) begin
      ivl_r <= ivl_sum[IB-1:0];
    end
  end

  // ---- tick, phase and coils ----
  assign active   = (mode_r != jssd_pkg::MODE_IDLE);
  assign tick_inc = (tick_r < jssd_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign fire     = active && (tick_inc >= ivl_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= jssd_pkg::MODE_IDLE;
      phase_r <= '0;
      tick_r  <= '0;
      coil_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_in;
      if (mode_in != mode_r) begin
        tick_r  <= '0;
        phase_r <= '0;
      end
    end else if (load) begin
      if (active) begin
        tick_r <= fire ? '0 : tick_inc;
      end
      if (fire) begin
        coil_r  <= jssd_pkg::half_step(phase_r);
        phase_r <= (mode_r == jssd_pkg::MODE_FWD) ? phase_r + 1'b1 : phase_r - 1'b1;
      end
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= {4'b0000, ivl_r, mode_r, fire,
                      fire ? jssd_pkg::half_step(phase_r) : coil_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---- checks ----
  a_mul_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == jssd_pkg::ST_MUL))
    else $error("multiplier finished outside its state");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == jssd_pkg::ST_DIV))
    else $error("divider finished outside its state");

  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4]) |-> (out_tdata[6:5] != jssd_pkg::MODE_IDLE))
    else $error("step flagged while idle");

  a_idle_ivl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[6:5] == jssd_pkg::MODE_IDLE)) |-> (out_tdata[11:7] == '0))
    else $error("interval nonzero while idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result overwritten while stalled");

endmodule

// ===== dv/jssd_drive_checker.sv =====
// ----------------------------------------------------------------------------
// jssd_drive_checker
// Watches the sample, result and register channels of the half-step drive,
// keeps its own copy of the drive state and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jssd_drive_checker
  import jssd_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [15:0]                         out_tdata,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]             cfg_index,
  input  logic [REG_BITS-1:0]                 cfg_data,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    logic [COIL_BITS-1:0] coil;
    logic                 stepped;
    mode_t                mode;
    logic [IVL_BITS-1:0]  ivl;
  } tick_result_t;

  localparam logic [COIL_BITS-1:0] COIL_SEQ [8] = '{
    4'b0001, 4'b0011, 4'b0010, 4'b0110, 4'b0100, 4'b1100, 4'b1000, 4'b1001
  };

  // register copies
  logic [REG_BITS-1:0]   fwd_thr, rev_thr;
  logic [IVL_BITS-1:0]   fast_ivl, slow_ivl;
  // drive state
  mode_t                 drive_mode;
  logic [PHASE_BITS-1:0] phase;
  logic [IVL_BITS-1:0]   tick_cnt;
  logic [COIL_BITS-1:0]  coil_held;

  tick_result_t due_results[$];
  tick_result_t want;
  int           errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [IVL_BITS-1:0] clamp_ivl(input longint v);
    if (v < 0) return '0;
    if (v > longint'(TICK_MAX)) return TICK_MAX;
    return IVL_BITS'(v);
  endfunction

  // linear sample-to-interval mapping, signed so fast > slow just inverts it
  function automatic logic [IVL_BITS-1:0] step_interval_for(
    input mode_t m, input logic [SAMPLE_BITS-1:0] s);
    longint full_scale, f, r, fa, sl, sv;
    full_scale = (longint'(1) << SAMPLE_BITS) - 1;
    f  = longint'(fwd_thr);
    r  = longint'(rev_thr);
    fa = longint'(fast_ivl);
    sl = longint'(slow_ivl);
    sv = longint'(s);
    if (m == MODE_FWD) begin
      if (f >= full_scale) return clamp_ivl(sl);
      return clamp_ivl(sl - ((sv - f) * (sl - fa)) / (full_scale - f));
    end
    if (r == 0) return clamp_ivl(fa);
    return clamp_ivl(fa + (sv * (sl - fa)) / r);
  endfunction

  // one tick of the sequencer: updates the state copy, returns the result
  function automatic tick_result_t advance_drive(input logic [SAMPLE_BITS-1:0] s);
    tick_result_t res;
    mode_t        nxt;
    if (longint'(s) >= longint'(fwd_thr))      nxt = MODE_FWD;
    else if (longint'(s) <= longint'(rev_thr)) nxt = MODE_REV;
    else                                       nxt = MODE_IDLE;
    if (nxt != drive_mode) begin
      tick_cnt   = '0;
      phase      = '0;
      drive_mode = nxt;
    end
    res.stepped = 1'b0;
    res.ivl     = '0;
    if (drive_mode != MODE_IDLE) begin
      res.ivl = step_interval_for(drive_mode, s);
      if (tick_cnt < TICK_MAX) tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= res.ivl) begin
        coil_held = COIL_SEQ[phase];
        if (drive_mode == MODE_FWD) phase = phase + 1'b1;
        else                        phase = phase - 1'b1;
        tick_cnt    = '0;
        res.stepped = 1'b1;
      end
    end
    res.coil = coil_held;
    res.mode = drive_mode;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fwd_thr    = FWD_THR_RST;
      rev_thr    = REV_THR_RST;
      fast_ivl   = FAST_RST;
      slow_ivl   = SLOW_RST;
      drive_mode = MODE_IDLE;
      phase      = '0;
      tick_cnt   = '0;
      coil_held  = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_FWD_THR: fwd_thr  = cfg_data;
          REG_REV_THR: rev_thr  = cfg_data;
          REG_FAST:    fast_ivl = cfg_data[IVL_BITS-1:0];
          REG_SLOW:    slow_ivl = cfg_data[IVL_BITS-1:0];
          default: ;
        endcase
      end
      // compare before queueing: a sample taken on this edge cannot be out yet
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("%0t: result item with none due: %h", $realtime, out_tdata);
        end else begin
          want = due_results.pop_front();
          if (out_tdata[3:0] !== want.coil || out_tdata[4] !== want.stepped ||
              out_tdata[6:5] !== want.mode || out_tdata[11:7] !== want.ivl ||
              out_tdata[15:12] !== 4'h0) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("%0t: mismatch exp coil=%h stepped=%b mode=%0d ivl=%0d pad=0",
                       $realtime, want.coil, want.stepped, want.mode, want.ivl);
              $display("%0t:          got coil=%h stepped=%b mode=%0d ivl=%0d pad=%h",
                       $realtime, out_tdata[3:0], out_tdata[4], out_tdata[6:5],
                       out_tdata[11:7], out_tdata[15:12]);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        due_results.push_back(advance_drive(in_tdata[SAMPLE_BITS-1:0]));
    end
    fail_count <= errors;
    pending    <= due_results.size();
  end

endmodule

// ===== dv/tb_joystick_stepper_half_step_drive.sv =====
// ----------------------------------------------------------------------------
// tb_joystick_stepper_half_step_drive
// Streams joystick samples through the half-step drive under a run of
// register settings (defaults, extremes, overlapping thresholds, zero spans,
// inverted and zero intervals, random) with bursty input and a stalling
// result side; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_stepper_half_step_drive;
  import jssd_pkg::*;

  localparam int unsigned SB          = SAMPLE_BITS_DEF;
  localparam int unsigned IN_W        = ((SB + 7) / 8) * 8;
  localparam int          SAMPLE_MAX  = (1 << SB) - 1;
  localparam int          NUM_PHASES  = 16;
  localparam int          PHASE_ITEMS = 108;   // random items per setting
  localparam int          QUIET_LIMIT = 2000;  // cycles with no item moving
  localparam int          TAIL_CYCLES = 20;    // idle margin after the last result

  typedef enum int { SEG_FWD, SEG_REV, SEG_IDLE, SEG_EDGE, SEG_NOISE } segment_t;
  typedef enum int { STALL_NONE, STALL_RANDOM, STALL_LONG } stall_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_W-1:0]         in_tdata = '0;     // [SB-1:0] joystick_sample
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [15:0]             out_tdata;         // [3:0] coil_pattern, [4] stepped,
                                              // [6:5] run_mode, [11:7] step_interval
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_FWD_THR;
  logic [REG_BITS-1:0]     cfg_data = '0;

  int     fail_count;
  int     pending;
  int     quiet_cycles = 0;
  stall_t stall_style = STALL_NONE;
  int     hold_left = 0;

  // thresholds as last written, used only to aim samples at a mode
  int fwd_thr_set = FWD_THR_RST;
  int rev_thr_set = REV_THR_RST;

  // sender burst shaping
  int burst_left = 0;
  int max_gap    = 0;
  int max_burst  = 1;

  // directed ticks under reset settings: extremes, thresholds and their
  // neighbours, alternating bit patterns, and runs long enough to step
  int directed_samples[22] = '{
    1023, 1023, 1023, 1023, 600, 599, 401, 400, 0, 0, 0, 0,
    682, 341, 512, 1, 601, 1022, 399, 0, 500, 1023
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  joystick_stepper_half_step_drive dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  jssd_drive_checker #(.SAMPLE_BITS(SB)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side back-pressure, style chosen per setting
  always @(posedge clk) begin
    case (stall_style)
      STALL_NONE:   out_tready <= 1'b1;
      STALL_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left != 0) begin
          hold_left <= hold_left - 1;
        end else begin
          out_tready <= !out_tready;
          hold_left  <= out_tready ? $urandom_range(0, 12) : $urandom_range(1, 8);
        end
      end
    endcase
  end

  // watchdog: any item moving on any channel counts as progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // all four registers back to back, valid held high between them
  task automatic write_regs(input logic [REG_BITS-1:0] fwd, input logic [REG_BITS-1:0] rev,
                            input logic [REG_BITS-1:0] fast, input logic [REG_BITS-1:0] slow);
    reg_idx_t            order [4] = '{REG_FWD_THR, REG_REV_THR, REG_FAST, REG_SLOW};
    logic [REG_BITS-1:0] vals [4];
    vals = '{fwd, rev, fast, slow};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid   <= 1'b0;
    fwd_thr_set = fwd;
    rev_thr_set = rev;
  endtask

  // one tick; valid stays up afterwards so the next item can follow at once
  task automatic send_sample(input int s);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, max_burst);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(s);
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic int clip_sample(input int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  // sample aimed at one region of the current thresholds; forward wins overlaps
  function automatic int pick_sample(input segment_t seg);
    int rev_top;
    rev_top = (rev_thr_set < fwd_thr_set) ? rev_thr_set : fwd_thr_set - 1;
    case (seg)
      SEG_FWD:
        if (fwd_thr_set <= SAMPLE_MAX) return $urandom_range(SAMPLE_MAX, fwd_thr_set);
      SEG_REV:
        if (rev_top >= 0) return $urandom_range(rev_top, 0);
      SEG_IDLE:
        if (rev_thr_set + 1 <= fwd_thr_set - 1)
          return $urandom_range(fwd_thr_set - 1, rev_thr_set + 1);
      SEG_EDGE:
        case ($urandom_range(0, 7))
          0: return clip_sample(fwd_thr_set - 1);
          1: return clip_sample(fwd_thr_set);
          2: return clip_sample(fwd_thr_set + 1);
          3: return clip_sample(rev_thr_set - 1);
          4: return clip_sample(rev_thr_set);
          5: return clip_sample(rev_thr_set + 1);
          6: return 0;
          default: return SAMPLE_MAX;
        endcase
      default: ;
    endcase
    return $urandom_range(SAMPLE_MAX, 0);
  endfunction

  // runs of ticks held in one mode so the step counter gets somewhere,
  // broken up by noise and threshold-edge samples
  task automatic send_random_ticks(input int count);
    segment_t seg;
    int       seg_len;
    int       sent;
    int       pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 32)      seg = SEG_FWD;
      else if (pick < 64) seg = SEG_REV;
      else if (pick < 74) seg = SEG_IDLE;
      else if (pick < 84) seg = SEG_EDGE;
      else                seg = SEG_NOISE;
      seg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 48) : $urandom_range(1, 20);
      for (int k = 0; k < seg_len && sent < count; k++) begin
        send_sample(pick_sample(seg));
        sent++;
      end
    end
  endtask

  initial begin
    logic [REG_BITS-1:0] f, r, fa, sl;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
      if (phase_no > 0) begin
        // registers only change with nothing in flight
        in_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        case (phase_no)
          1: begin f = 1023; r = 0;    fa = 31; sl = 0;  end  // zero spans, inverted
          2: begin f = 300;  r = 700;  fa = 0;  sl = 31; end  // overlapping thresholds
          3: begin f = 1;    r = 1;    fa = 1;  sl = 1;  end
          4: begin f = 1022; r = 1022; fa = 31; sl = 31; end  // counter runs to saturation
          5: begin f = 0;    r = 0;    fa = 0;  sl = 0;  end  // always forward, every tick
          6: begin f = 1022; r = 1;    fa = 0;  sl = 31; end
          NUM_PHASES - 1: begin
            f = FWD_THR_RST; r = REV_THR_RST; fa = FAST_RST; sl = SLOW_RST;
          end
          default: begin
            f  = $urandom_range(SAMPLE_MAX, 0);
            r  = $urandom_range(SAMPLE_MAX, 0);
            // upper bits on the interval writes are don't-care
            fa = $urandom_range(REG_BITS == 10 ? 1023 : 31, 0);
            sl = $urandom_range(REG_BITS == 10 ? 1023 : 31, 0);
          end
        endcase
        write_regs(f, r, fa, sl);
      end

      stall_style <= (phase_no == 0) ? STALL_NONE : stall_t'($urandom_range(0, 2));
      max_gap     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      max_burst   = $urandom_range(1, 12);

      if (phase_no == 0)
        foreach (directed_samples[k]) send_sample(directed_samples[k]);
      send_random_ticks(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/jssd_pkg.sv
src/jssd_mul.sv
src/jssd_div.sv
src/joystick_stepper_half_step_drive.sv
dv/jssd_drive_checker.sv
dv/tb_joystick_stepper_half_step_drive.sv
